[src/goal_horizon_clamp_core_assert.svh]
// Assertion macros for the goal horizon clamp checker
`ifndef GOAL_HORIZON_CLAMP_CORE_ASSERT_SVH
`define GOAL_HORIZON_CLAMP_CORE_ASSERT_SVH

// same-cycle implication
`define GHC_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("goal_horizon_clamp_core: assertion failed");

// implication after a fixed number of cycles
`define GHC_ASSERT_DLY(lbl, ck, rs, ante, n, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> ##n (cons)) \
    else $error("goal_horizon_clamp_core: delayed assertion failed");

`endif

[src/ghc_pkg.sv]
// Types, constants and angle table for the goal horizon clamp
`timescale 1ns / 1ps
package ghc_pkg;

  localparam int DW        = 33;   // delta width
  localparam int RAD_W     = 66;   // radicand, padded to whole bit pairs
  localparam int SQ_REM_W  = 36;
  localparam int ROOT_W    = 33;
  localparam int SQ_N      = 33;   // root bits
  localparam int CW        = 44;   // cordic x/y
  localparam int ZW        = 20;   // cordic angle, Q16
  localparam int NORM_LOG  = 40;
  localparam int HEAD_MAX  = 25736;
  localparam int HALF_PI_Q16 = 102944;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [31:0] goal_z;
    logic signed [15:0] goal_heading;
  } ghc_req_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [15:0] out_heading;
    logic               clamped;
  } ghc_result_t;

  typedef struct packed {
    ghc_req_t              req;
    logic signed [DW-1:0]  dx;
    logic signed [DW-1:0]  dy;
    logic signed [DW-1:0]  dz;
    logic                  clamp;
  } ghc_ctx_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [15:0] goal_heading;
    logic               clamp;
  } ghc_hctx_t;

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    mag = v[DW-1] ? DW'(-v) : v;
  endfunction

  // arctangent of 2^-i in Q16 radians
  function automatic logic signed [ZW-1:0] stage_angle(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0: a = ZW'(51472);
      1: a = ZW'(30386);
      2: a = ZW'(16055);
      3: a = ZW'(8150);
      4: a = ZW'(4091);
      5: a = ZW'(2047);
      6: a = ZW'(1024);
      default: a = (i <= 16) ? ZW'(1 << (16 - i)) : '0;
    endcase
    stage_angle = a;
  endfunction

endpackage

[src/ghc_sqrt_cell.sv]
// One bit of the pipelined restoring square root
`timescale 1ns / 1ps
module ghc_sqrt_cell #(
  parameter int CTX_W = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [ghc_pkg::RAD_W-1:0]    in_rad,
  input  logic [ghc_pkg::SQ_REM_W-1:0] in_rem,
  input  logic [ghc_pkg::ROOT_W-1:0]   in_root,
  input  logic [CTX_W-1:0]             in_ctx,
  output logic                         out_valid,
  output logic [ghc_pkg::RAD_W-1:0]    out_rad,
  output logic [ghc_pkg::SQ_REM_W-1:0] out_rem,
  output logic [ghc_pkg::ROOT_W-1:0]   out_root,
  output logic [CTX_W-1:0]             out_ctx
);
  import ghc_pkg::*;

  logic [SQ_REM_W-1:0] rem_sh;
  logic [SQ_REM_W-1:0] trial;
  logic                take;

  assign rem_sh = {in_rem[SQ_REM_W-3:0], in_rad[RAD_W-1 -: 2]};
  assign trial  = {1'b0, in_root, 2'b01};
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_rad  <= in_rad << 2;
    out_rem  <= take ? rem_sh - trial : rem_sh;
    out_root <= {in_root[ROOT_W-2:0], take};
    out_ctx  <= in_ctx;
  end

endmodule

[src/ghc_div_cell.sv]
// One quotient bit of the pipelined restoring divider
`timescale 1ns / 1ps
module ghc_div_cell #(
  parameter int QW    = 17,
  parameter int CTX_W = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [ghc_pkg::DW-1:0]   in_rem,
  input  logic [ghc_pkg::DW-1:0]   in_den,
  input  logic [QW-1:0]            in_num,
  input  logic [QW-1:0]            in_q,
  input  logic [CTX_W-1:0]         in_ctx,
  output logic                     out_valid,
  output logic [ghc_pkg::DW-1:0]   out_rem,
  output logic [ghc_pkg::DW-1:0]   out_den,
  output logic [QW-1:0]            out_num,
  output logic [QW-1:0]            out_q,
  output logic [CTX_W-1:0]         out_ctx
);
  import ghc_pkg::*;

  logic [DW:0] r2;
  logic        take;

  assign r2   = {in_rem, in_num[QW-1]};
  assign take = r2 >= {1'b0, in_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_rem <= take ? DW'(r2 - {1'b0, in_den}) : DW'(r2);
    out_den <= in_den;
    out_num <= in_num << 1;
    out_q   <= {in_q[QW-2:0], take};
    out_ctx <= in_ctx;
  end

endmodule

[src/ghc_cordic_cell.sv]
// One vectoring CORDIC micro-rotation
`timescale 1ns / 1ps
module ghc_cordic_cell #(
  parameter int IDX   = 0,
  parameter int CTX_W = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [ghc_pkg::CW-1:0] in_x,
  input  logic signed [ghc_pkg::CW-1:0] in_y,
  input  logic signed [ghc_pkg::ZW-1:0] in_z,
  input  logic [CTX_W-1:0]              in_ctx,
  output logic                          out_valid,
  output logic signed [ghc_pkg::CW-1:0] out_x,
  output logic signed [ghc_pkg::CW-1:0] out_y,
  output logic signed [ghc_pkg::ZW-1:0] out_z,
  output logic [CTX_W-1:0]              out_ctx
);
  import ghc_pkg::*;

  localparam logic signed [ZW-1:0] ANGLE = stage_angle(IDX);

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;

  assign xs = in_x >>> IDX;
  assign ys = in_y >>> IDX;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_y > 0) begin
      out_x <= in_x + ys;
      out_y <= in_y - xs;
      out_z <= in_z + ANGLE;
    end else begin
      out_x <= in_x - ys;
      out_y <= in_y + xs;
      out_z <= in_z - ANGLE;
    end
    out_ctx <= in_ctx;
  end

endmodule

[src/goal_horizon_clamp_core.sv]
// Goal horizon clamp: pulls a goal back onto the horizon circle around the start
`timescale 1ns / 1ps
// Fully pipelined: one item may start every cycle while busy is low, and its
// result appears with done. The pipeline is the bit-per-stage square root
// (33 cells), the bit-per-stage divider (FRACTION_BITS + 1 cells), the
// CORDIC chain (CORDIC_STAGES cells) and eight stages of setup and scaling.
// busy is high only during reset. Results cannot be held off: capture the
// result struct in the cycle done is high. Write horizon only while no item
// is in flight.
module goal_horizon_clamp_core #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  ghc_pkg::ghc_req_t    req,
  input  logic                 horizon_we,
  input  logic [30:0]          horizon_wdata,
  output logic                 done,
  output ghc_pkg::ghc_result_t result
);
  import ghc_pkg::*;

  localparam int QW      = FRACTION_BITS + 1;
  localparam int NUM_W   = 32 + FRACTION_BITS;
  localparam int P_W     = DW + QW;
  localparam int CTX_W   = $bits(ghc_ctx_t);
  localparam int HCTX_W  = $bits(ghc_hctx_t);
  localparam int LATENCY = 42 + FRACTION_BITS + CORDIC_STAGES;
  localparam logic [65:0] NORM_TOP = 66'd1 << (NORM_LOG + 1);

  logic [30:0] horizon;
  logic        accept;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      horizon <= '0;
    end else if (horizon_we) begin
      horizon <= horizon_wdata;
    end
  end

  // deltas
  logic     a_valid;
  ghc_ctx_t a_ctx;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    a_ctx.req   <= req;
    a_ctx.dx    <= {req.goal_x[31], req.goal_x} - {req.start_x[31], req.start_x};
    a_ctx.dy    <= {req.goal_y[31], req.goal_y} - {req.start_y[31], req.start_y};
    a_ctx.dz    <= {req.goal_z[31], req.goal_z} - {req.start_z[31], req.start_z};
    a_ctx.clamp <= 1'b0;
  end

  // squares
  logic        b_valid;
  ghc_ctx_t    b_ctx;
  logic [63:0] b_sqx;
  logic [63:0] b_sqy;
  logic [61:0] b_hsq;
  logic [31:0] a_ax;
  logic [31:0] a_ay;

  assign a_ax = 32'(mag(a_ctx.dx));
  assign a_ay = 32'(mag(a_ctx.dy));

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_ctx <= a_ctx;
    b_sqx <= a_ax * a_ax;
    b_sqy <= a_ay * a_ay;
    b_hsq <= horizon * horizon;
  end

  // sum and clamp test
  logic        c_valid;
  ghc_ctx_t    c_ctx;
  logic [64:0] c_rad;
  logic [64:0] b_sum;

  assign b_sum = {1'b0, b_sqx} + {1'b0, b_sqy};

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    c_ctx.req   <= b_ctx.req;
    c_ctx.dx    <= b_ctx.dx;
    c_ctx.dy    <= b_ctx.dy;
    c_ctx.dz    <= b_ctx.dz;
    c_ctx.clamp <= (horizon != '0) && (b_sum > {3'b0, b_hsq});
    c_rad       <= b_sum;
  end

  // square root chain
  logic                sq_valid [0:SQ_N];
  logic [RAD_W-1:0]    sq_rad   [0:SQ_N];
  logic [SQ_REM_W-1:0] sq_rem   [0:SQ_N];
  logic [ROOT_W-1:0]   sq_root  [0:SQ_N];
  logic [CTX_W-1:0]    sq_ctx   [0:SQ_N];

  assign sq_valid[0] = c_valid;
  assign sq_rad[0]   = {1'b0, c_rad};
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_ctx[0]   = c_ctx;

  for (genvar i = 0; i < SQ_N; i++) begin : g_sq
    ghc_sqrt_cell #(.CTX_W(CTX_W)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sq_valid[i]),
      .in_rad    (sq_rad[i]),
      .in_rem    (sq_rem[i]),
      .in_root   (sq_root[i]),
      .in_ctx    (sq_ctx[i]),
      .out_valid (sq_valid[i+1]),
      .out_rad   (sq_rad[i+1]),
      .out_rem   (sq_rem[i+1]),
      .out_root  (sq_root[i+1]),
      .out_ctx   (sq_ctx[i+1])
    );
  end

  // divider setup: ratio = (horizon * 2^F + d/2) / d
  logic             dp_valid;
  logic [DW-1:0]    dp_rem;
  logic [DW-1:0]    dp_den;
  logic [QW-1:0]    dp_num;
  logic [CTX_W-1:0] dp_ctx;
  logic [DW-1:0]    sq_d;
  logic [NUM_W-1:0] sq_num;

  assign sq_d   = (sq_root[SQ_N] == '0) ? DW'(1) : sq_root[SQ_N];
  assign sq_num = {1'b0, horizon, {FRACTION_BITS{1'b0}}} + NUM_W'(sq_d >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      dp_valid <= 1'b0;
    end else begin
      dp_valid <= sq_valid[SQ_N];
    end
  end

  always_ff @(posedge clk) begin
    dp_rem <= DW'(sq_num[NUM_W-1:QW]);
    dp_num <= sq_num[QW-1:0];
    dp_den <= sq_d;
    dp_ctx <= sq_ctx[SQ_N];
  end

  // divider chain
  logic             dv_valid [0:QW];
  logic [DW-1:0]    dv_rem   [0:QW];
  logic [DW-1:0]    dv_den   [0:QW];
  logic [QW-1:0]    dv_num   [0:QW];
  logic [QW-1:0]    dv_q     [0:QW];
  logic [CTX_W-1:0] dv_ctx   [0:QW];

  assign dv_valid[0] = dp_valid;
  assign dv_rem[0]   = dp_rem;
  assign dv_den[0]   = dp_den;
  assign dv_num[0]   = dp_num;
  assign dv_q[0]     = '0;
  assign dv_ctx[0]   = dp_ctx;

  for (genvar i = 0; i < QW; i++) begin : g_dv
    ghc_div_cell #(.QW(QW), .CTX_W(CTX_W)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv_valid[i]),
      .in_rem    (dv_rem[i]),
      .in_den    (dv_den[i]),
      .in_num    (dv_num[i]),
      .in_q      (dv_q[i]),
      .in_ctx    (dv_ctx[i]),
      .out_valid (dv_valid[i+1]),
      .out_rem   (dv_rem[i+1]),
      .out_den   (dv_den[i+1]),
      .out_num   (dv_num[i+1]),
      .out_q     (dv_q[i+1]),
      .out_ctx   (dv_ctx[i+1])
    );
  end

  // scaling products
  logic           mu_valid;
  ghc_ctx_t       mu_ctx;
  ghc_ctx_t       dv_last;
  logic [P_W-1:0] mu_px;
  logic [P_W-1:0] mu_py;
  logic [P_W-1:0] mu_pz;

  assign dv_last = dv_ctx[QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      mu_valid <= 1'b0;
    end else begin
      mu_valid <= dv_valid[QW];
    end
  end

  always_ff @(posedge clk) begin
    mu_ctx <= dv_last;
    mu_px  <= mag(dv_last.dx) * dv_q[QW];
    mu_py  <= mag(dv_last.dy) * dv_q[QW];
    mu_pz  <= mag(dv_last.dz) * dv_q[QW];
  end

  // rounding, sign and offset
  logic                 fn_valid;
  ghc_hctx_t            fn_ctx;
  logic signed [DW-1:0] fn_dx;
  logic signed [DW-1:0] fn_dy;
  logic [P_W-1:0]       qx;
  logic [P_W-1:0]       qy;
  logic [P_W-1:0]       qz;
  logic [31:0]          ox;
  logic [31:0]          oy;
  logic [31:0]          oz;

  localparam logic [P_W-1:0] HALF = P_W'(1) << (FRACTION_BITS - 1);

  always_comb begin
    qx = (mu_px + HALF) >> FRACTION_BITS;
    qy = (mu_py + HALF) >> FRACTION_BITS;
    qz = (mu_pz + HALF) >> FRACTION_BITS;
    ox = mu_ctx.req.start_x + (mu_ctx.dx[DW-1] ? -qx[31:0] : qx[31:0]);
    oy = mu_ctx.req.start_y + (mu_ctx.dy[DW-1] ? -qy[31:0] : qy[31:0]);
    oz = mu_ctx.req.start_z + (mu_ctx.dz[DW-1] ? -qz[31:0] : qz[31:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fn_valid <= 1'b0;
    end else begin
      fn_valid <= mu_valid;
    end
  end

  always_ff @(posedge clk) begin
    fn_ctx.out_x        <= mu_ctx.clamp ? ox : mu_ctx.req.goal_x;
    fn_ctx.out_y        <= mu_ctx.clamp ? oy : mu_ctx.req.goal_y;
    fn_ctx.out_z        <= mu_ctx.clamp ? oz : mu_ctx.req.goal_z;
    fn_ctx.goal_heading <= mu_ctx.req.goal_heading;
    fn_ctx.clamp        <= mu_ctx.clamp;
    fn_dx               <= mu_ctx.dx;
    fn_dy               <= mu_ctx.dy;
  end

  // normalise and fold into the right half plane
  logic                 nm_valid;
  logic signed [CW-1:0] nm_x;
  logic signed [CW-1:0] nm_y;
  logic signed [ZW-1:0] nm_z;
  logic [HCTX_W-1:0]    nm_ctx;
  logic signed [CW-1:0] nx;
  logic signed [CW-1:0] ny;
  logic signed [CW-1:0] rx;
  logic signed [CW-1:0] ry;
  logic signed [ZW-1:0] rz;
  logic [65:0]          nmag;
  logic [DW-1:0]        max_m;

  always_comb begin
    nx    = {{(CW-DW){fn_dx[DW-1]}}, fn_dx};
    ny    = {{(CW-DW){fn_dy[DW-1]}}, fn_dy};
    max_m = (mag(fn_dx) > mag(fn_dy)) ? mag(fn_dx) : mag(fn_dy);
    nmag  = 66'(max_m);
    for (int j = 5; j >= 0; j--) begin
      if ((nmag != '0) && ((nmag << (1 << j)) < NORM_TOP)) begin
        nx   = nx <<< (1 << j);
        ny   = ny <<< (1 << j);
        nmag = nmag << (1 << j);
      end
    end
    rx = nx;
    ry = ny;
    rz = '0;
    if (nx < 0) begin
      if (ny >= 0) begin
        rx = ny;
        ry = -nx;
        rz = ZW'(HALF_PI_Q16);
      end else begin
        rx = -ny;
        ry = nx;
        rz = -ZW'(HALF_PI_Q16);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nm_valid <= 1'b0;
    end else begin
      nm_valid <= fn_valid;
    end
  end

  always_ff @(posedge clk) begin
    nm_x   <= rx;
    nm_y   <= ry;
    nm_z   <= rz;
    nm_ctx <= fn_ctx;
  end

  // cordic chain
  logic                 cr_valid [0:CORDIC_STAGES];
  logic signed [CW-1:0] cr_x     [0:CORDIC_STAGES];
  logic signed [CW-1:0] cr_y     [0:CORDIC_STAGES];
  logic signed [ZW-1:0] cr_z     [0:CORDIC_STAGES];
  logic [HCTX_W-1:0]    cr_ctx   [0:CORDIC_STAGES];

  assign cr_valid[0] = nm_valid;
  assign cr_x[0]     = nm_x;
  assign cr_y[0]     = nm_y;
  assign cr_z[0]     = nm_z;
  assign cr_ctx[0]   = nm_ctx;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cr
    ghc_cordic_cell #(.IDX(i), .CTX_W(HCTX_W)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cr_valid[i]),
      .in_x      (cr_x[i]),
      .in_y      (cr_y[i]),
      .in_z      (cr_z[i]),
      .in_ctx    (cr_ctx[i]),
      .out_valid (cr_valid[i+1]),
      .out_x     (cr_x[i+1]),
      .out_y     (cr_y[i+1]),
      .out_z     (cr_z[i+1]),
      .out_ctx   (cr_ctx[i+1])
    );
  end

  // heading rounding, saturation and result register
  ghc_hctx_t              cr_last;
  logic signed [ZW-1:0]   zr;
  logic signed [15:0]     head;

  assign cr_last = cr_ctx[CORDIC_STAGES];

  always_comb begin
    zr = (cr_z[CORDIC_STAGES] + ZW'(4)) >>> 3;
    if (zr > HEAD_MAX) begin
      head = 16'(HEAD_MAX);
    end else if (zr < -HEAD_MAX) begin
      head = -16'(HEAD_MAX);
    end else begin
      head = zr[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cr_valid[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    result.out_x       <= cr_last.out_x;
    result.out_y       <= cr_last.out_y;
    result.out_z       <= cr_last.out_z;
    result.out_heading <= cr_last.clamp ? head : cr_last.goal_heading;
    result.clamped     <= cr_last.clamp;
  end

endmodule

[src/ghc_checker.sv]
// Port-level checks for the goal horizon clamp, bound to the top level
`timescale 1ns / 1ps
`include "goal_horizon_clamp_core_assert.svh"
module ghc_checker #(
  parameter int LATENCY = 74
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input ghc_pkg::ghc_req_t    req,
  input logic                 done,
  input ghc_pkg::ghc_result_t result
);
  import ghc_pkg::*;

  `GHC_ASSERT_IMPL(a_done_has_item, clk, rst, done, $past(start && !busy, LATENCY))
  `GHC_ASSERT_DLY(a_item_gives_done, clk, rst, start && !busy, LATENCY, done)
  `GHC_ASSERT_IMPL(a_head_range, clk, rst, done && result.clamped, (result.out_heading <= 16'sd25736) && (result.out_heading >= -16'sd25736))
  `GHC_ASSERT_IMPL(a_pass_through, clk, rst, done && !result.clamped, (result.out_x == $past(req.goal_x, LATENCY)) && (result.out_z == $past(req.goal_z, LATENCY)))

endmodule

bind goal_horizon_clamp_core ghc_checker #(.LATENCY(LATENCY)) u_ghc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .req    (req),
  .done   (done),
  .result (result)
);

[verif/tb_goal_horizon_clamp_core.sv]
// Testbench for goal_horizon_clamp_core: directed and random poses checked against a local predictor
`timescale 1ns / 1ps
module tb_goal_horizon_clamp_core;
  import ghc_pkg::*;

  localparam int LATENCY = 74;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  ghc_req_t req = '0;
  logic horizon_we = 1'b0;
  logic [30:0] horizon_wdata = '0;
  logic done;
  ghc_result_t result;

  goal_horizon_clamp_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .horizon_we(horizon_we), .horizon_wdata(horizon_wdata),
    .done(done), .result(result)
  );

  always #5 clk = ~clk;

  logic [30:0] horizon_now = '0;
  ghc_result_t pending_goals[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int clamp_count = 0;
  longint cycles = 0;
  int idle_pct = 33;

  function automatic logic [63:0] abs64(input longint v);
    abs64 = v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint asr64(input longint v, input int s);
    asr64 = v >>> s;
  endfunction

  function automatic logic [63:0] root_of(input logic hi, input logic [63:0] lo);
    logic [63:0] rem, root, pair, trial;
    rem = 0;
    root = 0;
    for (int i = 32; i >= 0; i--) begin
      pair = (i == 32) ? {63'b0, hi} : ((lo >> (2 * i)) & 64'd3);
      rem = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic longint pull_in(input longint delta, input logic [63:0] ratio);
    logic [63:0] q;
    q = (abs64(delta) * ratio + 64'd32768) >> 16;
    return delta < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint arc_step(input int i);
    case (i)
      0: return 51472;
      1: return 30386;
      2: return 16055;
      3: return 8150;
      4: return 4091;
      5: return 2047;
      6: return 1024;
      default: return (i <= 16) ? (longint'(1) << (16 - i)) : 0;
    endcase
  endfunction

  function automatic logic [15:0] bearing(input longint x0, input longint y0);
    longint x, y, z, t, xs, ys;
    logic [63:0] m;
    x = x0;
    y = y0;
    z = 0;
    m = abs64(x) > abs64(y) ? abs64(x) : abs64(y);
    while (m != 0 && m < (64'd1 << 40)) begin
      x = x * 2;
      y = y * 2;
      m = m * 2;
    end
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HALF_PI_Q16;
      end else begin
        t = x; x = -y; y = t; z = -HALF_PI_Q16;
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs = asr64(x, i);
      ys = asr64(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += arc_step(i);
      end else begin
        x -= ys; y += xs; z -= arc_step(i);
      end
    end
    z = asr64(z + 4, 3);
    if (z > HEAD_MAX) z = HEAD_MAX;
    if (z < -HEAD_MAX) z = -HEAD_MAX;
    return 16'(z);
  endfunction

  function automatic ghc_result_t local_goal(input ghc_req_t r, input logic [30:0] hz);
    ghc_result_t o;
    longint sx, sy, sz, dx, dy, dz;
    logic [63:0] ax, ay, sqx, lo, d, ratio, hz64;
    logic hi, clamp;
    sx = longint'(r.start_x);
    sy = longint'(r.start_y);
    sz = longint'(r.start_z);
    dx = longint'(r.goal_x) - sx;
    dy = longint'(r.goal_y) - sy;
    dz = longint'(r.goal_z) - sz;
    ax = abs64(dx);
    ay = abs64(dy);
    sqx = ax * ax;
    lo = sqx + ay * ay;
    hi = lo < sqx;
    hz64 = 64'(hz);
    clamp = hz != 0 && (hi || lo > hz64 * hz64);
    o.out_x = r.goal_x;
    o.out_y = r.goal_y;
    o.out_z = r.goal_z;
    o.out_heading = r.goal_heading;
    o.clamped = clamp;
    if (clamp) begin
      d = root_of(hi, lo);
      if (d == 0) d = 1;
      ratio = ((hz64 << 16) + d / 2) / d;
      o.out_x = 32'(sx + pull_in(dx, ratio));
      o.out_y = 32'(sy + pull_in(dy, ratio));
      o.out_z = 32'(sz + pull_in(dz, ratio));
      o.out_heading = bearing(dx, dy);
    end
    return o;
  endfunction

  always @(posedge clk) begin
    ghc_result_t want;
    cycles <= cycles + 1;
    if (!rst && done) begin
      results_seen <= results_seen + 1;
      if (pending_goals.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        errors <= errors + 1;
      end else begin
        want = pending_goals.pop_front();
        if (want.clamped) clamp_count <= clamp_count + 1;
        if (want.out_x !== result.out_x)
          $display("%0t: out_x expected %h actual %h", $time, want.out_x, result.out_x);
        if (want.out_y !== result.out_y)
          $display("%0t: out_y expected %h actual %h", $time, want.out_y, result.out_y);
        if (want.out_z !== result.out_z)
          $display("%0t: out_z expected %h actual %h", $time, want.out_z, result.out_z);
        if (want.out_heading !== result.out_heading)
          $display("%0t: out_heading expected %h actual %h", $time, want.out_heading,
                   result.out_heading);
        if (want.clamped !== result.clamped)
          $display("%0t: clamped expected %b actual %b", $time, want.clamped, result.clamped);
        if (want !== result) errors <= errors + 1;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("goal_horizon_clamp_core verification failed");
      $finish;
    end
  end

  task automatic send_item(input ghc_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_goals.push_back(local_goal(r, horizon_now));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_goals.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic set_horizon(input logic [30:0] h);
    drain();
    horizon_we <= 1'b1;
    horizon_wdata <= h;
    @(negedge clk);
    horizon_we <= 1'b0;
    horizon_now = h;
  endtask

  function automatic logic [31:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
      default: return 32'($signed($urandom_range(1 << 26)) - (1 << 25));
    endcase
  endfunction

  function automatic ghc_req_t rand_pose(input int mode);
    ghc_req_t r;
    r.start_x = rand_coord(mode);
    r.start_y = rand_coord(mode);
    r.start_z = rand_coord(mode);
    r.goal_x = r.start_x + rand_coord(mode);
    r.goal_y = r.start_y + rand_coord(mode);
    r.goal_z = r.start_z + rand_coord(mode);
    if (mode == 0) begin
      r.goal_x = $urandom();
      r.goal_y = $urandom();
      r.goal_z = $urandom();
    end
    r.goal_heading = 16'($urandom());
    return r;
  endfunction

  function automatic ghc_req_t pose(input logic [31:0] sx, sy, gx, gy, input logic [15:0] h);
    ghc_req_t r;
    r.start_x = sx; r.start_y = sy; r.start_z = 32'h7FFF_FFFF;
    r.goal_x = gx; r.goal_y = gy; r.goal_z = 32'h8000_0000;
    r.goal_heading = h;
    return r;
  endfunction

  task automatic test_horizon_off;
    send_item(pose(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF));
    send_item(pose(0, 0, 32'h0001_0000, 0, 16'h8000));
    send_item(pose(5, 5, 5, 5, 16'd25736));
  endtask

  task automatic test_directed_clamp;
    set_horizon(31'h0001_0000);
    send_item(pose(0, 0, 0, 0, 16'hFFFF));
    send_item(pose(0, 0, 32'h0001_0000, 0, 16'd100));
    send_item(pose(0, 0, 32'h0001_0001, 0, 16'd100));
    send_item(pose(0, 0, 32'h0005_0000, 0, 0));
    send_item(pose(0, 0, 0, 32'h0005_0000, 0));
    send_item(pose(0, 0, 32'hFFFB_0000, 0, 0));
    send_item(pose(0, 0, 0, 32'hFFFB_0000, 0));
    send_item(pose(0, 0, 32'hFFFB_0000, 32'hFFFB_0000, 0));
    send_item(pose(0, 0, 32'hFFFB_0000, 32'h0005_0000, 0));
    send_item(pose(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
    send_item(pose(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0));
    send_item(pose(0, 0, 1, 1, 0));
    set_horizon(31'h7FFF_FFFF);
    send_item(pose(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
    send_item(pose(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 16'h1234));
    set_horizon(31'd1);
    send_item(pose(0, 0, 1, 0, 0));
    send_item(pose(0, 0, 1, 1, 0));
    send_item(pose(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
  endtask

  task automatic test_random(input int n);
    int mode;
    logic [30:0] h;
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 0) begin
        case ($urandom_range(3))
          0: h = 31'($urandom());
          1: h = 31'($urandom_range(1 << 26));
          2: h = 31'($urandom_range(1 << 22));
          default: h = 0;
        endcase
        set_horizon(h);
      end
      idle_pct = (i >= 600 && i < 900) ? 0 : 33;
      mode = $urandom_range(2);
      send_item(rand_pose(mode));
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_horizon_off();
    test_directed_clamp();
    test_random(1900);
    drain();
    $display("sent %0d poses, %0d results checked, %0d clamped", items_sent, results_seen,
             clamp_count);
    $display("horizon swept from zero and one to full scale with random idling");
    if (errors == 0 && pending_goals.size() == 0)
      $display("goal_horizon_clamp_core verification clean");
    else
      $display("goal_horizon_clamp_core verification failed");
    $finish;
  end
endmodule

[goal_horizon_clamp_core.f]
+incdir+src
src/ghc_pkg.sv
src/ghc_sqrt_cell.sv
src/ghc_div_cell.sv
src/ghc_cordic_cell.sv
src/goal_horizon_clamp_core.sv
src/ghc_checker.sv
verif/tb_goal_horizon_clamp_core.sv
